### rtl/fla_pkg.sv
// Shared types, codes and the CRC-8 step for the framed link with retry.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
package fla_pkg;

    // Selector codes on the input channel
    localparam logic [1:0] FN_RX   = 2'd0;
    localparam logic [1:0] FN_TICK = 2'd1;
    localparam logic [1:0] FN_LOAD = 2'd2;

    // Result kinds
    localparam logic [2:0] K_TX      = 3'd0;
    localparam logic [2:0] K_RX      = 3'd1;
    localparam logic [2:0] K_OK      = 3'd2;
    localparam logic [2:0] K_CRCERR  = 3'd3;
    localparam logic [2:0] K_FAIL    = 3'd4;
    localparam logic [2:0] K_NOISE   = 3'd5;
    localparam logic [2:0] K_LEN     = 3'd6;
    localparam logic [2:0] K_TIMEOUT = 3'd7;

    // Configuration register indexes and reset values
    localparam logic [1:0]  CFG_TIMEOUT = 2'd0;
    localparam logic [1:0]  CFG_RETRY   = 2'd1;
    localparam logic [1:0]  CFG_SYNC    = 2'd2;
    localparam logic [15:0] TIMEOUT_RST = 16'd1000;
    localparam logic [3:0]  RETRY_RST   = 4'd5;
    localparam logic [7:0]  SYNC_RST    = 8'hD5;

    // Reflected Dallas/Maxim polynomial
    localparam logic [7:0] CRC_POLY = 8'h8C;

    // Job queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_WAIT,
        PH_RETRY,
        PH_HDR,
        PH_DATA,
        PH_CRC
    } link_phase_t;

    typedef enum logic [1:0] {
        JOB_EMIT,
        JOB_SEND,
        JOB_WRITE
    } job_op_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SYNC,
        BK_LEN,
        BK_BODY,
        BK_CRC
    } back_state_t;

    // EMIT: kind/data/acked; SEND: data = sync byte, aux = length;
    // WRITE: data = command byte, aux = store address
    typedef struct packed {
        job_op_t    op;
        logic [2:0] kind;
        logic [7:0] data;
        logic [7:0] aux;
        logic       acked;
    } job_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [3:0]  retry_limit;
        logic [7:0]  sync_value;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    // One byte through the reflected CRC-8
    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] c;
        c = acc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/fla_queue.sv
// Short in-order job queue between the front classifier and the back sequencer.
// Depends on fla_pkg (job_t, queue_stat_t, QDEPTH).
`timescale 1ns / 1ps
module fla_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  fla_pkg::job_t         din,
    input  logic                  pop,
    output fla_pkg::job_t         dout,
    output fla_pkg::queue_stat_t  stat
);
    import fla_pkg::*;

    job_t           q_mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]   count_reg, count_next;

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store job payload
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout       = q_mem_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (QAW+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

### rtl/fla_front.sv
// Front part: accepts items, runs the link phase, timer, retry and receive state,
// and turns each item into at most one job for the back part. Depends on fla_pkg.
`timescale 1ns / 1ps
module fla_front #(
    parameter int RX_LEN_LIMIT = 32,
    parameter int CMD_DEPTH    = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [1:0]            s_tuser,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  fla_pkg::cfg_t         cfg,
    input  fla_pkg::queue_stat_t  q_stat,
    output logic                  push,
    output fla_pkg::job_t         job
);
    import fla_pkg::*;

    localparam int RW = $clog2(RX_LEN_LIMIT);
    localparam int LW = $clog2(CMD_DEPTH + 1);

    link_phase_t   phase_reg, phase_next;
    logic [7:0]    crc_reg, crc_next;
    logic [RW-1:0] rx_expected_reg, rx_expected_next;
    logic [RW-1:0] rx_count_reg, rx_count_next;
    logic          first_bit7_reg, first_bit7_next;
    logic [15:0]   elapsed_reg, elapsed_next;
    logic          timer_reg, timer_next;
    logic [LW-1:0] cmd_length_reg, cmd_length_next;
    logic [LW-1:0] load_index_reg, load_index_next;
    logic          pending_reg, pending_next;
    logic [3:0]    retries_reg, retries_next;

    logic          fire;
    logic          len_ok;
    logic          idle_like;
    logic          store_room;
    logic [RW-1:0] cnt_inc;
    logic [LW-1:0] idx_after;

    assign s_tready   = !q_stat.full;
    assign fire       = s_tvalid && s_tready;
    assign len_ok     = (32'(s_tdata) < RX_LEN_LIMIT);
    assign idle_like  = (phase_reg == PH_IDLE) || (phase_reg == PH_RETRY);
    assign store_room = (load_index_reg < LW'(CMD_DEPTH));
    assign cnt_inc    = rx_count_reg + 1'b1;
    assign idx_after  = store_room ? load_index_reg + 1'b1 : load_index_reg;

    // Next state of the link
    always_comb begin
        phase_next       = phase_reg;
        crc_next         = crc_reg;
        rx_expected_next = rx_expected_reg;
        rx_count_next    = rx_count_reg;
        first_bit7_next  = first_bit7_reg;
        elapsed_next     = elapsed_reg;
        timer_next       = timer_reg;
        cmd_length_next  = cmd_length_reg;
        load_index_next  = load_index_reg;
        pending_next     = pending_reg;
        retries_next     = retries_reg;
        if (fire) begin
            case (s_tuser)
                FN_RX: begin
                    case (phase_reg)
                        PH_HDR: begin
                            if (len_ok) begin
                                rx_expected_next = s_tdata[RW-1:0];
                                rx_count_next    = '0;
                                crc_next         = '0;
                                first_bit7_next  = 1'b0;
                                phase_next       = (s_tdata == 8'd0) ? PH_CRC : PH_DATA;
                            end else begin
                                phase_next = PH_IDLE;
                                timer_next = 1'b0;
                            end
                        end
                        PH_DATA: begin
                            if (rx_count_reg == '0) begin
                                first_bit7_next = s_tdata[7];
                            end
                            crc_next      = crc8_step(crc_reg, s_tdata);
                            rx_count_next = cnt_inc;
                            if (cnt_inc >= rx_expected_reg) begin
                                phase_next = PH_CRC;
                            end
                        end
                        PH_CRC: begin
                            if (first_bit7_reg) begin
                                pending_next = 1'b0;
                            end
                            phase_next = PH_IDLE;
                            timer_next = 1'b0;
                        end
                        default: begin
                            if (s_tdata == cfg.sync_value) begin
                                phase_next   = PH_HDR;
                                elapsed_next = '0;
                                timer_next   = 1'b1;
                            end
                        end
                    endcase
                end
                FN_TICK: begin
                    if (idle_like) begin
                        if (pending_reg) begin
                            if (retries_reg <= 4'd1) begin
                                retries_next = '0;
                                pending_next = 1'b0;
                                phase_next   = PH_IDLE;
                            end else begin
                                retries_next = retries_reg - 1'b1;
                                phase_next   = PH_WAIT;
                                elapsed_next = '0;
                                timer_next   = 1'b1;
                            end
                        end
                    end else if (timer_reg) begin
                        if (elapsed_reg >= cfg.timeout_ticks) begin
                            phase_next   = pending_reg ? PH_RETRY : PH_IDLE;
                            timer_next   = 1'b0;
                            elapsed_next = '0;
                        end else begin
                            elapsed_next = elapsed_reg + 1'b1;
                        end
                    end
                end
                FN_LOAD: begin
                    load_index_next = idx_after;
                    if (s_tlast) begin
                        cmd_length_next = idx_after;
                        load_index_next = '0;
                        pending_next    = (idx_after != '0);
                        retries_next    = cfg.retry_limit;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Job toward the back part
    always_comb begin
        push      = 1'b0;
        job.op    = JOB_EMIT;
        job.kind  = K_TX;
        job.data  = '0;
        job.aux   = '0;
        job.acked = 1'b0;
        if (fire) begin
            case (s_tuser)
                FN_RX: begin
                    case (phase_reg)
                        PH_HDR: begin
                            if (!len_ok) begin
                                push     = 1'b1;
                                job.kind = K_LEN;
                            end
                        end
                        PH_DATA: begin
                            push     = 1'b1;
                            job.kind = K_RX;
                            job.data = s_tdata;
                        end
                        PH_CRC: begin
                            push      = 1'b1;
                            job.kind  = (crc_reg == s_tdata) ? K_OK : K_CRCERR;
                            job.acked = first_bit7_reg;
                        end
                        default: begin
                            if (s_tdata != cfg.sync_value) begin
                                push     = 1'b1;
                                job.kind = K_NOISE;
                            end
                        end
                    endcase
                end
                FN_TICK: begin
                    if (idle_like) begin
                        if (pending_reg) begin
                            push = 1'b1;
                            if (retries_reg <= 4'd1) begin
                                job.kind = K_FAIL;
                            end else begin
                                job.op   = JOB_SEND;
                                job.data = cfg.sync_value;
                                job.aux  = 8'(cmd_length_reg);
                            end
                        end
                    end else if (timer_reg && (elapsed_reg >= cfg.timeout_ticks)) begin
                        push     = 1'b1;
                        job.kind = K_TIMEOUT;
                    end
                end
                FN_LOAD: begin
                    if (store_room) begin
                        push     = 1'b1;
                        job.op   = JOB_WRITE;
                        job.data = s_tdata;
                        job.aux  = 8'(load_index_reg);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            crc_reg         <= '0;
            rx_expected_reg <= '0;
            rx_count_reg    <= '0;
            first_bit7_reg  <= 1'b0;
            elapsed_reg     <= '0;
            timer_reg       <= 1'b0;
            cmd_length_reg  <= '0;
            load_index_reg  <= '0;
            pending_reg     <= 1'b0;
            retries_reg     <= '0;
        end else begin
            phase_reg       <= phase_next;
            crc_reg         <= crc_next;
            rx_expected_reg <= rx_expected_next;
            rx_count_reg    <= rx_count_next;
            first_bit7_reg  <= first_bit7_next;
            elapsed_reg     <= elapsed_next;
            timer_reg       <= timer_next;
            cmd_length_reg  <= cmd_length_next;
            load_index_reg  <= load_index_next;
            pending_reg     <= pending_next;
            retries_reg     <= retries_next;
        end
    end

endmodule

### rtl/fla_back.sv
// Back part: holds the command store, executes queued jobs, drives the registered
// result channel; frames go one byte a cycle unless stalled. Depends on fla_pkg.
`timescale 1ns / 1ps
module fla_back #(
    parameter int CMD_DEPTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  fla_pkg::job_t         head,
    input  fla_pkg::queue_stat_t  q_stat,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [2:0]            m_tuser,   // kind
    output logic [15:0]           m_tdata,   // [7:0] value, [8] acked, [15:9] zero
    output logic                  m_tlast
);
    import fla_pkg::*;

    localparam int AW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int LW = $clog2(CMD_DEPTH + 1);

    back_state_t   state_reg, state_next;
    logic [LW-1:0] len_reg, len_next;
    logic [LW-1:0] idx_reg, idx_next;
    logic [7:0]    crc_reg, crc_next;
    logic [7:0]    sync_reg, sync_next;

    logic          m_valid_reg, m_valid_next;
    logic [2:0]    kind_reg;
    logic [7:0]    value_reg;
    logic          acked_reg;
    logic          last_reg;

    logic [7:0]    cmd_mem [CMD_DEPTH];
    logic [7:0]    rd_data_reg;

    logic          out_free;
    logic          load;
    logic [2:0]    o_kind;
    logic [7:0]    o_value;
    logic          o_acked;
    logic          o_last;
    logic          wr_en;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [LW-1:0] idx_inc;

    assign out_free = !m_valid_reg || m_tready;
    assign idx_inc  = idx_reg + 1'b1;

    // Sequencer outputs: pop, store access and the result to load
    always_comb begin
        pop     = 1'b0;
        load    = 1'b0;
        o_kind  = K_TX;
        o_value = '0;
        o_acked = 1'b0;
        o_last  = 1'b0;
        wr_en   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty) begin
                    case (head.op)
                        JOB_WRITE: begin
                            wr_en = 1'b1;
                            pop   = 1'b1;
                        end
                        JOB_EMIT: begin
                            if (out_free) begin
                                pop     = 1'b1;
                                load    = 1'b1;
                                o_kind  = head.kind;
                                o_value = head.data;
                                o_acked = head.acked;
                                o_last  = 1'b1;
                            end
                        end
                        default: begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_SYNC: begin
                load    = out_free;
                o_value = sync_reg;
            end
            BK_LEN: begin
                load    = out_free;
                o_value = 8'(len_reg);
                rd_en   = out_free;
            end
            BK_BODY: begin
                load    = out_free;
                o_value = rd_data_reg;
                if (out_free && (idx_inc != len_reg)) begin
                    rd_en   = 1'b1;
                    rd_addr = idx_inc[AW-1:0];
                end
            end
            BK_CRC: begin
                load    = out_free;
                o_value = crc_reg;
                o_last  = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        state_next = state_reg;
        len_next   = len_reg;
        idx_next   = idx_reg;
        crc_next   = crc_reg;
        sync_next  = sync_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_stat.empty && (head.op == JOB_SEND)) begin
                    state_next = BK_SYNC;
                    sync_next  = head.data;
                    len_next   = head.aux[LW-1:0];
                    idx_next   = '0;
                    crc_next   = '0;
                end
            end
            BK_SYNC: begin
                if (out_free) begin
                    state_next = BK_LEN;
                end
            end
            BK_LEN: begin
                if (out_free) begin
                    state_next = (len_reg == '0) ? BK_CRC : BK_BODY;
                end
            end
            BK_BODY: begin
                if (out_free) begin
                    crc_next = crc8_step(crc_reg, rd_data_reg);
                    idx_next = idx_inc;
                    if (idx_inc == len_reg) begin
                        state_next = BK_CRC;
                    end
                end
            end
            BK_CRC: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign m_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Frame walk payload and output register
    always_ff @(posedge aclk) begin
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        crc_reg  <= crc_next;
        sync_reg <= sync_next;
        if (load) begin
            kind_reg  <= o_kind;
            value_reg <= o_value;
            acked_reg <= o_acked;
            last_reg  <= o_last;
        end
    end

    // Command store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            cmd_mem[head.aux[AW-1:0]] <= head.data;
        end
        if (rd_en) begin
            rd_data_reg <= cmd_mem[rd_addr];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {7'd0, acked_reg, value_reg};
    assign m_tlast  = last_reg;

endmodule

### rtl/framed_link_with_retry.sv
// Top level of the framed half-duplex link with retry: configuration registers,
// front classifier, job queue and back sequencer. Depends on fla_pkg and all fla_ modules.
//
//   Channel   Direction  Handshake          Payload
//   s_        in         s_tvalid/s_tready  s_tuser func, s_tdata byte, s_tlast load last
//   m_        out        m_tvalid/m_tready  m_tuser kind, m_tdata value+acked, m_tlast
//   cfg_      in         cfg_valid/ready    cfg_index register, cfg_data value
//
// The front takes one item per cycle while the four-entry job queue has room.
// A frame send occupies the back from taking the job through sync, length, payload
// bytes read one a cycle from the store while the output is not stalled, and CRC;
// every other job is handled in the idle state alone.
// Reset (aresetn low, synchronous) clears the phase, timer, retry and queue state;
// the command store is not cleared. A stalled m_ side fills the queue, then
// drops s_tready; configuration writes are always taken.
`timescale 1ns / 1ps
module framed_link_with_retry #(
    parameter int RX_LEN_LIMIT = 32,
    parameter int CMD_DEPTH    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,   // func
    input  logic [7:0]  s_tdata,   // data_byte
    input  logic        s_tlast,   // load_last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  m_tuser,   // kind
    output logic [15:0] m_tdata,   // [7:0] value, [8] acked, [15:9] zero
    output logic        m_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import fla_pkg::*;

    cfg_t        cfg_reg;
    queue_stat_t q_stat;
    job_t        push_job;
    job_t        head_job;
    logic        q_push;
    logic        q_pop;

    assign cfg_ready = 1'b1;

    // Configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
            cfg_reg.retry_limit   <= RETRY_RST;
            cfg_reg.sync_value    <= SYNC_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_TIMEOUT: cfg_reg.timeout_ticks <= cfg_data;
                CFG_RETRY:   cfg_reg.retry_limit   <= cfg_data[3:0];
                CFG_SYNC:    cfg_reg.sync_value    <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    fla_front #(
        .RX_LEN_LIMIT (RX_LEN_LIMIT),
        .CMD_DEPTH    (CMD_DEPTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .push     (q_push),
        .job      (push_job)
    );

    fla_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (push_job),
        .pop     (q_pop),
        .dout    (head_job),
        .stat    (q_stat)
    );

    fla_back #(
        .CMD_DEPTH (CMD_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head_job),
        .q_stat   (q_stat),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Queue never pushed when full nor popped when empty
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full) else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty) else $error("job popped from an empty queue");

    // Front stalls only on a full queue
    a_ready_tracks_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_stat.full) else $error("input stalled with queue room");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid) else $error("result valid after reset");

endmodule
